/* hw/rtl/assert_macros.svh */
// assertion macros used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is low
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/bped_pkg.sv */
// types and constants of the bit-parallel edit distance block
`timescale 1ns / 1ps

package bped_pkg;

  localparam int DIST_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int POS_W      = 6;
  localparam int QLEN_W     = 7;
  localparam int LIM_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int WALK_STEP  = 8;
  localparam int OFF_W      = 8;

  localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_en;
    logic start_en;
    logic match_en;
    logic adv_en;
    logic walk_init;
    logic walk_en;
    logic out_load;
  } ctrl_t;

endpackage

/* hw/rtl/bit_parallel_edit_distance.sv */
// bit-parallel edit distance: an accepted word passes through the prep, column walk and done states,
// a step word first through the match and advance states; the walk covers 8 entries per cycle, and a new
// word is taken only once the result is loaded in the done state, which waits while a result is stalled.
// reset clears the vectors, the running distance, both config registers and the control state;
// the query store keeps its contents and is undefined until loaded.
`timescale 1ns / 1ps

module bit_parallel_edit_distance #(
  parameter int MAX_QUERY = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bped_pkg::CMD_W-1:0]      in_command,
  input  logic [bped_pkg::POS_W-1:0]      in_position,
  input  logic [bped_pkg::CHAR_W-1:0]     in_char_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bped_pkg::DIST_W-1:0]     out_distance,
  output logic                            out_within_limit,
  output logic                            out_may_still_match,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bped_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bped_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CHUNKS = (MAX_QUERY + bped_pkg::WALK_STEP - 1) / bped_pkg::WALK_STEP;

  bped_pkg::ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  bped_controller #(
    .CHUNKS (CHUNKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ctrl       (ctrl)
  );

  bped_datapath #(
    .MAX_QUERY (MAX_QUERY)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .in_position         (in_position),
    .in_char_byte        (in_char_byte),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_distance        (out_distance),
    .out_within_limit    (out_within_limit),
    .out_may_still_match (out_may_still_match)
  );

endmodule

/* hw/rtl/bped_controller.sv */
// sequencer for load, start, step and the column walk
`timescale 1ns / 1ps

module bped_controller #(
  parameter int CHUNKS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [bped_pkg::CMD_W-1:0] in_command,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bped_pkg::ctrl_t            ctrl
);

  localparam int CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_ADV   = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.capture  = 1'b1;
          ctrl.load_en  = (in_command == bped_pkg::CMD_LOAD);
          ctrl.start_en = (in_command == bped_pkg::CMD_START);
          state_nxt     = (in_command == bped_pkg::CMD_STEP) ? S_MATCH : S_PREP;
        end
      end
      S_MATCH: begin
        ctrl.match_en = 1'b1;
        state_nxt     = S_ADV;
      end
      S_ADV: begin
        ctrl.adv_en = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        ctrl.walk_init = 1'b1;
        cnt_nxt        = CNT_W'(CHUNKS - 1);
        state_nxt      = S_WALK;
      end
      S_WALK: begin
        ctrl.walk_en = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          ctrl.out_load = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ctrl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/bped_datapath.sv */
// query store, delta vectors, column step and reachability walk
`timescale 1ns / 1ps

module bped_datapath #(
  parameter int MAX_QUERY = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bped_pkg::ctrl_t                 ctrl,
  input  logic [bped_pkg::POS_W-1:0]      in_position,
  input  logic [bped_pkg::CHAR_W-1:0]     in_char_byte,
  input  logic                            cfg_we,
  input  logic [bped_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bped_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [bped_pkg::DIST_W-1:0]     out_distance,
  output logic                            out_within_limit,
  output logic                            out_may_still_match
);

  localparam int W      = MAX_QUERY;
  localparam int LEN_W  = $clog2(MAX_QUERY + 1);
  localparam int STEP   = bped_pkg::WALK_STEP;
  localparam int CHUNKS = (MAX_QUERY + STEP - 1) / STEP;
  localparam int PAD_W  = CHUNKS * STEP;
  localparam int DW     = bped_pkg::DIST_W;
  localparam int OW     = bped_pkg::OFF_W;
  localparam int SUM_W  = DW + 2;

  logic [bped_pkg::CHAR_W-1:0] qb_r [W];

  logic [W-1:0]                  pv_r, pv_nxt;
  logic [W-1:0]                  mv_r, mv_nxt;
  logic [DW-1:0]                 col_r, col_nxt;
  logic [bped_pkg::QLEN_W-1:0]   qlen_r, qlen_nxt;
  logic [bped_pkg::LIM_W-1:0]    lim_r, lim_nxt;
  logic [bped_pkg::CHAR_W-1:0]   tgt_r;
  logic [W-1:0]                  eq_r, eq_nxt;
  logic [PAD_W-1:0]              pw_r, pw_nxt;
  logic [PAD_W-1:0]              qw_r, qw_nxt;
  logic signed [OW-1:0]          off_r, off_nxt;
  logic signed [OW-1:0]          min_r, min_nxt;
  logic [DW-1:0]                 dist_r;
  logic                          within_r, within_nxt;
  logic                          reach_r, reach_nxt;

  logic [LEN_W-1:0] m;
  logic [W-1:0]     mask;
  logic [W-1:0]     last;

  assign m = (qlen_r > bped_pkg::QLEN_W'(MAX_QUERY)) ? LEN_W'(MAX_QUERY) : LEN_W'(qlen_r);

  for (genvar i = 0; i < W; i++) begin : g_lane
    assign mask[i]   = (LEN_W'(i) < m);
    assign last[i]   = (LEN_W'(i + 1) == m);
    assign eq_nxt[i] = (qb_r[i] == tgt_r) && mask[i];

    always_ff @(posedge clk) begin
      if (ctrl.load_en && (in_position == bped_pkg::POS_W'(i))) begin
        qb_r[i] <= in_char_byte;
      end
    end
  end

  // column step
  logic [W-1:0]  xv, xh, ph, mh, ph2, mh2, carry_sum;
  logic          ph_last, mh_last;
  logic [DW-1:0] d_inc, d_dec;

  always_comb begin
    xv        = eq_r | mv_r;
    carry_sum = (eq_r & pv_r) + pv_r;
    xh        = (carry_sum ^ pv_r) | eq_r;
    ph        = mv_r | ~(xh | pv_r);
    mh        = pv_r & xh;
    ph_last   = |(ph & last);
    mh_last   = |(mh & last);
    d_inc     = (ph_last && (col_r != bped_pkg::DIST_MAX)) ? col_r + 1'b1 : col_r;
    d_dec     = (mh_last && (d_inc != '0)) ? d_inc - 1'b1 : d_inc;
    ph2       = (ph << 1) | W'(1);
    mh2       = mh << 1;
  end

  always_comb begin
    pv_nxt  = pv_r;
    mv_nxt  = mv_r;
    col_nxt = col_r;
    if (ctrl.start_en) begin
      pv_nxt  = mask;
      mv_nxt  = '0;
      col_nxt = DW'(m);
    end else if (ctrl.adv_en) begin
      if (m == '0) begin
        pv_nxt  = '0;
        mv_nxt  = '0;
        col_nxt = (col_r != bped_pkg::DIST_MAX) ? col_r + 1'b1 : col_r;
      end else begin
        pv_nxt  = (mh2 | ~(xv | ph2)) & mask;
        mv_nxt  = (ph2 & xv) & mask;
        col_nxt = d_dec;
      end
    end
  end

  always_comb begin
    qlen_nxt = qlen_r;
    lim_nxt  = lim_r;
    if (cfg_we) begin
      case (cfg_index)
        bped_pkg::CFG_QUERY_LENGTH: qlen_nxt = cfg_data[bped_pkg::QLEN_W-1:0];
        bped_pkg::CFG_MAX_DISTANCE: lim_nxt  = cfg_data;
        default: begin
          qlen_nxt = qlen_r;
        end
      endcase
    end
  end

  // walk upward from the bottom entry, one chunk of the column per cycle
  logic [STEP-1:0]      top_p, top_q;
  logic signed [OW-1:0] run_off, run_min;

  always_comb begin
    top_p   = pw_r[PAD_W-1 -: STEP];
    top_q   = qw_r[PAD_W-1 -: STEP];
    run_off = off_r;
    run_min = min_r;
    for (int k = STEP - 1; k >= 0; k--) begin
      if (top_p[k]) begin
        run_off = run_off - OW'(1);
      end else if (top_q[k]) begin
        run_off = run_off + OW'(1);
      end
      if (run_off < run_min) begin
        run_min = run_off;
      end
    end
  end

  always_comb begin
    pw_nxt  = pw_r;
    qw_nxt  = qw_r;
    off_nxt = off_r;
    min_nxt = min_r;
    if (ctrl.walk_init) begin
      pw_nxt  = PAD_W'(pv_r & mask) << (PAD_W - W);
      qw_nxt  = PAD_W'(mv_r & mask) << (PAD_W - W);
      off_nxt = '0;
      min_nxt = '0;
    end else if (ctrl.walk_en) begin
      pw_nxt  = pw_r << STEP;
      qw_nxt  = qw_r << STEP;
      off_nxt = run_off;
      min_nxt = run_min;
    end
  end

  logic signed [SUM_W-1:0] reach_sum;

  assign reach_sum  = $signed({2'b00, col_r}) + $signed({{(SUM_W - OW){min_r[OW-1]}}, min_r});
  assign reach_nxt  = (reach_sum <= $signed({{(SUM_W - bped_pkg::LIM_W){1'b0}}, lim_r}));
  assign within_nxt = (col_r <= DW'(lim_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      mv_r   <= '0;
      col_r  <= '0;
      qlen_r <= '0;
      lim_r  <= '0;
    end else begin
      pv_r   <= pv_nxt;
      mv_r   <= mv_nxt;
      col_r  <= col_nxt;
      qlen_r <= qlen_nxt;
      lim_r  <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      tgt_r <= in_char_byte;
    end
    if (ctrl.match_en) begin
      eq_r <= eq_nxt;
    end
    pw_r  <= pw_nxt;
    qw_r  <= qw_nxt;
    off_r <= off_nxt;
    min_r <= min_nxt;
    if (ctrl.out_load) begin
      dist_r   <= col_r;
      within_r <= within_nxt;
      reach_r  <= reach_nxt;
    end
  end

  assign out_distance        = dist_r;
  assign out_within_limit    = within_r;
  assign out_may_still_match = reach_r;

endmodule

/* hw/rtl/bped_checker.sv */
// port checker for the edit distance block and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bped_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);

  // a stalled result word stays offered
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")

  // no result word pending right after reset
  `ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result word pending after reset")

  // an accepted word keeps the block busy for the next cycle
  `ASSERT_CLK(a_busy, in_valid && in_ready |=> !in_ready, "input taken while a word is in work")

  // a new result follows a busy cycle
  `ASSERT_CLK(a_out_after_work, $rose(out_valid) |-> $past(!in_ready), "result without work")

  // configuration is always taken
  `ASSERT_CLK(a_cfg_ready, cfg_ready, "configuration port stalled")

endmodule

bind bit_parallel_edit_distance bped_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cfg_ready (cfg_ready)
);
